// ===== design/jtts_pkg.sv =====
// Shared types, constants and TMS pattern tables for the JTAG TAP shift sequencer.
// Used by jtts_ctrl, jtts_dp and jtag_tap_shift_sequencer; no dependencies.
package jtts_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int IDX_W     = 3;
    localparam int CMD_W     = 3;

    // Stream widths: data word and bit count packed, padded to whole bytes
    localparam int IN_TDATA_W  = ((WORD_BITS + CNT_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = CMD_W + 1;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_RESET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IR       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DR       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IR_PAUSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DR_PAUSE = 3'd4;

    localparam logic [IDX_W-1:0] RESET_LAST_IDX = 3'd5;  // five TMS-high steps, then one low
    localparam logic [IDX_W-1:0] TAIL_LAST_IDX  = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESET,
        ST_HDR,
        ST_DATA,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        SEL_RESET,
        SEL_HDR,
        SEL_DATA,
        SEL_TAIL
    } step_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        step_sel_t sel;
        logic      idx_clr;
        logic      last_step;
    } dp_cmd_t;

    typedef struct packed {
        logic in_known;
        logic in_reset;
        logic in_first;
        logic in_has_data;
        logic in_last;
        logic reset_end;
        logic hdr_end;
        logic data_end;
        logic tail_end;
        logic has_data;
        logic last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] hdr_len(input logic [CMD_W-1:0] cmd);
        logic [IDX_W-1:0] len;
        unique case (cmd)
            CMD_DR:  len = 3'd4;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic hdr_tms(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        logic [4:0] pat;
        unique case (cmd)
            CMD_IR, CMD_IR_PAUSE: pat = 5'b00110;
            CMD_DR:               pat = 5'b00010;
            CMD_DR_PAUSE:         pat = 5'b00111;
            default:              pat = 5'b00000;
        endcase
        return (idx < 3'd5) ? pat[idx] : 1'b0;
    endfunction

    function automatic logic tail_tms(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        logic [1:0] pat;
        unique case (cmd)
            CMD_IR, CMD_DR, CMD_DR_PAUSE: pat = 2'b01;
            default:                      pat = 2'b00;
        endcase
        return (idx == '0) ? pat[0] : pat[1];
    endfunction

endpackage

// ===== design/jtts_ctrl.sv =====
// Controller state machine of the JTAG TAP shift sequencer: walks reset,
// header, data and tail phases. Depends on jtts_pkg.
module jtts_ctrl
    import jtts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.in_known)
                begin
                    if (stat.in_reset)
                        state_next = ST_RESET;
                    else if (stat.in_first)
                        state_next = ST_HDR;
                    else if (stat.in_has_data)
                        state_next = ST_DATA;
                    else if (stat.in_last)
                        state_next = ST_TAIL;
                end
            end
            ST_RESET:
            begin
                if (stat.out_free && stat.reset_end)
                    state_next = ST_IDLE;
            end
            ST_HDR:
            begin
                if (stat.out_free && stat.hdr_end)
                begin
                    if (stat.has_data)
                        state_next = ST_DATA;
                    else if (stat.last)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                if (stat.out_free && stat.data_end)
                    state_next = stat.last ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL:
            begin
                if (stat.out_free && stat.tail_end)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_RESET;
        cmd.idx_clr   = 1'b0;
        cmd.last_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RESET:
            begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_RESET;
                cmd.idx_clr   = stat.reset_end;
                cmd.last_step = stat.reset_end;
            end
            ST_HDR:
            begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_HDR;
                cmd.idx_clr   = stat.hdr_end;
                cmd.last_step = stat.hdr_end && !stat.has_data && !stat.last;
            end
            ST_DATA:
            begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_DATA;
                // hold the step index at zero so the tail starts at its first step
                cmd.idx_clr   = 1'b1;
                cmd.last_step = stat.data_end && !stat.last;
            end
            ST_TAIL:
            begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_TAIL;
                cmd.idx_clr   = stat.tail_end;
                cmd.last_step = stat.tail_end;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/jtts_dp.sv =====
// Datapath of the JTAG TAP shift sequencer: item registers, data shifter,
// step counters and the output step register. Depends on jtts_pkg.
module jtts_dp
    import jtts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CMD_W-1:0]     in_command,
    input  logic [WORD_BITS-1:0] in_data_word,
    input  logic [CNT_W-1:0]     in_bit_count,
    input  logic                 in_first,
    input  logic                 in_last,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_tms,
    output logic                 out_tdi,
    output logic                 out_last_step
);

    logic [CMD_W-1:0]     cmd_reg,  cmd_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [CNT_W-1:0]     rem_reg,  rem_next;
    logic [IDX_W-1:0]     idx_reg,  idx_next;
    logic                 last_reg, last_next;
    logic                 valid_reg, valid_next;
    logic                 tms_reg, tms_next;
    logic                 tdi_reg, tdi_next;
    logic                 lstep_reg, lstep_next;
    logic [CNT_W-1:0]     count_sat;
    logic                 step_tms;
    logic                 step_tdi;

    // Saturate oversized counts to the word width
    assign count_sat = (in_bit_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : in_bit_count;

    always_comb
    begin
        stat.in_known    = (in_command <= CMD_DR_PAUSE);
        stat.in_reset    = (in_command == CMD_RESET);
        stat.in_first    = in_first;
        stat.in_has_data = (count_sat != '0);
        stat.in_last     = in_last;
        stat.reset_end   = (idx_reg == RESET_LAST_IDX);
        stat.hdr_end     = (idx_reg == hdr_len(cmd_reg) - 3'd1);
        stat.data_end    = (rem_reg == CNT_W'(1));
        stat.tail_end    = (idx_reg == TAIL_LAST_IDX);
        stat.has_data    = (rem_reg != '0);
        stat.last        = last_reg;
        stat.out_free    = !valid_reg || out_ready;
    end

    always_comb
    begin
        step_tms = 1'b0;
        step_tdi = 1'b0;
        case (cmd.sel)
            SEL_RESET: step_tms = (idx_reg != RESET_LAST_IDX);
            SEL_HDR:   step_tms = hdr_tms(cmd_reg, idx_reg);
            SEL_DATA:
            begin
                step_tms = last_reg && (rem_reg == CNT_W'(1));
                step_tdi = data_reg[0];
            end
            SEL_TAIL:  step_tms = tail_tms(cmd_reg, idx_reg);
            default:   step_tms = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        tms_next   = tms_reg;
        tdi_next   = tdi_reg;
        lstep_next = lstep_reg;

        if (cmd.load)
        begin
            cmd_next  = in_command;
            data_next = in_data_word;
            rem_next  = count_sat;
            last_next = in_last;
            idx_next  = '0;
        end
        else if (cmd.emit)
        begin
            idx_next = cmd.idx_clr ? '0 : idx_reg + 3'd1;
            if (cmd.sel == SEL_DATA)
            begin
                // advance to the next data bit
                data_next = data_reg >> 1;
                rem_next  = rem_reg - CNT_W'(1);
            end
        end

        if (cmd.emit)
        begin
            valid_next = 1'b1;
            tms_next   = step_tms;
            tdi_next   = step_tdi;
            lstep_next = cmd.last_step;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
            cmd_reg   <= CMD_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            last_reg  <= last_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        tms_reg   <= tms_next;
        tdi_reg   <= tdi_next;
        lstep_reg <= lstep_next;
    end

    assign out_valid     = valid_reg;
    assign out_tms       = tms_reg;
    assign out_tdi       = tdi_reg;
    assign out_last_step = lstep_reg;

endmodule

// ===== design/jtag_tap_shift_sequencer.sv =====
// JTAG TAP shift sequencer: one TCK step (TMS, TDI) per cycle from each command item,
// while m_axis_tready does not stall the output. An accepted item is captured into the
// item registers, and its first step is then registered in the output step register.
// An item gives at most 39 steps (5 header + 32 data + 2 tail); a new item is taken only in idle.
// Reset: rst_n asynchronous active low; returns to idle and drops any pending step.
// Top level; depends on jtts_pkg, jtts_ctrl and jtts_dp.
module jtag_tap_shift_sequencer
    import jtts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_word, bit_count, zero pad
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // command, first_chunk
    input  logic                   s_axis_tlast,   // last_chunk
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // tms, tdi, zero pad
    output logic                   m_axis_tlast    // last_step
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     tms;
    logic     tdi;

    jtts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    jtts_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_command    (s_axis_tuser[CMD_W-1:0]),
        .in_data_word  (s_axis_tdata[WORD_BITS-1:0]),
        .in_bit_count  (s_axis_tdata[WORD_BITS +: CNT_W]),
        .in_first      (s_axis_tuser[CMD_W]),
        .in_last       (s_axis_tlast),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_tms       (tms),
        .out_tdi       (tdi),
        .out_last_step (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2){1'b0}}, tdi, tms};

endmodule
